/* src/sab_pkg.sv */
`default_nettype none
package sab_pkg;

  localparam int unsigned ChanMaxW = 6;
  localparam int unsigned NumW = 22;
  localparam int unsigned RecipW = 17;
  localparam int unsigned QuotW = 7;

  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [7:0] AlphaClear = 8'd0;
  localparam logic [NumW-1:0] Div = 22'd65025;
  // floor(2^32 / 65025), quotient estimate is low by at most one
  localparam logic [RecipW-1:0] Recip = 17'd66051;
  localparam int unsigned RecipShift = 32;

  localparam logic [15:0] MaskRed = 16'b1111100000000000;
  localparam logic [15:0] MaskGreen = 16'b0000011111100000;
  localparam logic [15:0] MaskBlue = 16'b0000000000011111;

  typedef enum logic {
    RegOriginX = 1'b0,
    RegOriginY = 1'b1
  } sab_reg_e;

  typedef struct packed {
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
  } sab_cfg_t;

  // stage load enables, one per pipeline register
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } sab_pipe_t;

endpackage
`default_nettype wire

/* src/sab_in_if.sv */
`default_nettype none
interface sab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sprite_blue;
  logic [7:0] sprite_green;
  logic [7:0] sprite_red;
  logic [7:0] sprite_alpha;
  logic [5:0] sprite_column;
  logic [5:0] sprite_row;
  logic [15:0] background_pixel;

  modport source (
    output valid, sprite_blue, sprite_green, sprite_red, sprite_alpha,
           sprite_column, sprite_row, background_pixel,
    input  ready
  );
  modport sink (
    input  valid, sprite_blue, sprite_green, sprite_red, sprite_alpha,
           sprite_column, sprite_row, background_pixel,
    output ready
  );
endinterface
`default_nettype wire

/* src/sab_out_if.sv */
`default_nettype none
interface sab_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [19:0] pixel_address;
  logic [15:0] blended_pixel;

  modport source (
    output valid, write_enable, pixel_address, blended_pixel,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_address, blended_pixel,
    output ready
  );
endinterface
`default_nettype wire

/* src/sab_cfg.sv */
`default_nettype none
module sab_cfg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output sab_pkg::sab_cfg_t     cfg_o
);
  import sab_pkg::*;

  logic [11:0] origin_x_q, origin_x_d;
  logic [11:0] origin_y_q, origin_y_d;
  logic        wr_en;
  sab_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = sab_reg_e'(paddr[2]);

  always_comb begin
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    prdata     = '0;
    case (reg_sel)
      RegOriginX: begin
        prdata = {20'd0, origin_x_q};
        if (wr_en) origin_x_d = pwdata[11:0];
      end
      RegOriginY: begin
        prdata = {20'd0, origin_y_q};
        if (wr_en) origin_y_d = pwdata[11:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else begin
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
    end
  end

  assign cfg_o.origin_x = $signed(origin_x_q);
  assign cfg_o.origin_y = $signed(origin_y_q);

endmodule
`default_nettype wire

/* src/sab_addr.sv */
`default_nettype none
module sab_addr #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int SPRITE_SIZE   = 64
) (
  input  wire logic              clk_i,
  input  wire sab_pkg::sab_pipe_t pipe_i,
  input  wire sab_pkg::sab_cfg_t cfg_i,
  input  wire logic [5:0]        column_i,
  input  wire logic [5:0]        row_i,
  input  wire logic [7:0]        alpha_i,
  output logic                   we_o,
  output logic [19:0]            addr_o
);
  import sab_pkg::*;

  localparam logic [11:0] WidthC = 12'(SCREEN_WIDTH);

  logic signed [12:0] sx, sy;
  logic               vis;
  logic               we1_q, we2_q, we3_q, we4_q;
  logic [10:0]        sx1_q, sy1_q;
  logic [22:0]        lin;
  logic [19:0]        addr2_q, addr3_q, addr4_q;

  assign sx = $signed({cfg_i.origin_x[11], cfg_i.origin_x}) + $signed({7'd0, column_i});
  assign sy = $signed({cfg_i.origin_y[11], cfg_i.origin_y}) + $signed({7'd0, row_i});

  assign vis = (32'(column_i) < SPRITE_SIZE) && (32'(row_i) < SPRITE_SIZE) &&
               !sx[12] && (32'(sx[11:0]) < SCREEN_WIDTH) &&
               !sy[12] && (32'(sy[11:0]) < SCREEN_HEIGHT);

  assign lin = 23'(sy1_q) * 23'(WidthC) + 23'(sx1_q);

  always_ff @(posedge clk_i) begin
    if (pipe_i.en1) begin
      we1_q <= vis && (alpha_i != AlphaClear);
      sx1_q <= sx[10:0];
      sy1_q <= sy[10:0];
    end
    if (pipe_i.en2) begin
      we2_q   <= we1_q;
      addr2_q <= we1_q ? lin[19:0] : '0;
    end
    if (pipe_i.en3) begin
      we3_q   <= we2_q;
      addr3_q <= addr2_q;
    end
    if (pipe_i.en4) begin
      we4_q   <= we3_q;
      addr4_q <= addr3_q;
    end
  end

  assign we_o   = we4_q;
  assign addr_o = addr4_q;

endmodule
`default_nettype wire

/* src/sab_chan.sv */
`default_nettype none
module sab_chan #(
  parameter int unsigned ChanW = 5
) (
  input  wire logic               clk_i,
  input  wire sab_pkg::sab_pipe_t pipe_i,
  input  wire logic [7:0]         alpha_i,
  input  wire logic [ChanW-1:0]   under_i,
  input  wire logic [7:0]         over_i,
  output logic [ChanW-1:0]        chan_o
);
  import sab_pkg::*;

  localparam int unsigned ProdW = NumW + RecipW;
  localparam logic [NumW-1:0] MaxV = NumW'((1 << ChanW) - 1);

  logic [13:0]        p_under1_q;
  logic [15:0]        p_over1_q;
  logic               opaque1_q, opaque2_q, opaque3_q;
  logic [ChanW-1:0]   trunc1_q, trunc2_q, trunc3_q;
  logic [NumW-1:0]    num2_q, num3_q;
  logic [QuotW-1:0]   qe3_q;
  logic [ProdW-1:0]   prod;
  logic [NumW-1:0]    rem;
  logic [QuotW-1:0]   quot;
  logic [ChanW-1:0]   chan4_q;

  // quotient estimate by reciprocal, then one compare and subtract
  assign prod = ProdW'(num2_q) * ProdW'(Recip);
  assign rem  = num3_q - NumW'(qe3_q) * Div;
  assign quot = (rem >= Div) ? qe3_q + QuotW'(1) : qe3_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.en1) begin
      p_under1_q <= 14'(AlphaOpaque - alpha_i) * 14'(under_i);
      p_over1_q  <= 16'(alpha_i) * 16'(over_i);
      opaque1_q  <= (alpha_i == AlphaOpaque);
      trunc1_q   <= over_i[7 -: ChanW];
    end
    if (pipe_i.en2) begin
      num2_q    <= NumW'(p_under1_q) * NumW'(AlphaOpaque) + NumW'(p_over1_q) * MaxV;
      opaque2_q <= opaque1_q;
      trunc2_q  <= trunc1_q;
    end
    if (pipe_i.en3) begin
      qe3_q     <= prod[RecipShift +: QuotW];
      num3_q    <= num2_q;
      opaque3_q <= opaque2_q;
      trunc3_q  <= trunc2_q;
    end
    if (pipe_i.en4) begin
      chan4_q <= opaque3_q ? trunc3_q : quot[ChanW-1:0];
    end
  end

  assign chan_o = chan4_q;

endmodule
`default_nettype wire

/* src/sprite_alpha_blend_rgb565_core.sv */
// Sprite pixel blender over an RGB565 frame buffer. One request (sprite pixel, its place in
// the sprite and the background pixel under it) enters per clock while ready is high, and
// its result leaves the output register of the four-stage datapath (products, numerator
// and address multiply, reciprocal multiply, correction); a stall on the result side holds
// every stage while bubbles still close up. The user must write origin_x and origin_y over
// the APB port only while no request is in flight (not enforced). Results with write_enable
// low carry address zero and the background pixel unchanged. No clearing pass after reset.
`default_nettype none
module sprite_alpha_blend_rgb565_core #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int SPRITE_SIZE   = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  sab_in_if.sink           sprite_i,
  sab_out_if.source        result_o
);
  import sab_pkg::*;

  sab_cfg_t   cfg;
  sab_pipe_t  pipe;
  logic       v1_q, v2_q, v3_q, v4_q;
  logic [15:0] bg1_q, bg2_q, bg3_q, bg4_q;
  logic       we;
  logic [19:0] addr;
  logic [4:0] red, blue;
  logic [5:0] green;

  sab_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a stage loads when empty or when the next one moves
  assign pipe.en4 = !v4_q || result_o.ready;
  assign pipe.en3 = !v3_q || pipe.en4;
  assign pipe.en2 = !v2_q || pipe.en3;
  assign pipe.en1 = !v1_q || pipe.en2;
  assign sprite_i.ready = pipe.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (pipe.en1) v1_q <= sprite_i.valid;
      if (pipe.en2) v2_q <= v1_q;
      if (pipe.en3) v3_q <= v2_q;
      if (pipe.en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe.en1) bg1_q <= sprite_i.background_pixel;
    if (pipe.en2) bg2_q <= bg1_q;
    if (pipe.en3) bg3_q <= bg2_q;
    if (pipe.en4) bg4_q <= bg3_q;
  end

  sab_addr #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .SPRITE_SIZE   (SPRITE_SIZE)
  ) u_addr (
    .clk_i    (clk_i),
    .pipe_i   (pipe),
    .cfg_i    (cfg),
    .column_i (sprite_i.sprite_column),
    .row_i    (sprite_i.sprite_row),
    .alpha_i  (sprite_i.sprite_alpha),
    .we_o     (we),
    .addr_o   (addr)
  );

  sab_chan #(.ChanW(5)) u_red (
    .clk_i   (clk_i),
    .pipe_i  (pipe),
    .alpha_i (sprite_i.sprite_alpha),
    .under_i (sprite_i.background_pixel[15:11]),
    .over_i  (sprite_i.sprite_red),
    .chan_o  (red)
  );

  sab_chan #(.ChanW(6)) u_green (
    .clk_i   (clk_i),
    .pipe_i  (pipe),
    .alpha_i (sprite_i.sprite_alpha),
    .under_i (sprite_i.background_pixel[10:5]),
    .over_i  (sprite_i.sprite_green),
    .chan_o  (green)
  );

  sab_chan #(.ChanW(5)) u_blue (
    .clk_i   (clk_i),
    .pipe_i  (pipe),
    .alpha_i (sprite_i.sprite_alpha),
    .under_i (sprite_i.background_pixel[4:0]),
    .over_i  (sprite_i.sprite_blue),
    .chan_o  (blue)
  );

  assign result_o.valid         = v4_q;
  assign result_o.write_enable  = we;
  assign result_o.pixel_address = addr;
  assign result_o.blended_pixel = we ? {red, green, blue} : bg4_q;

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !result_o.ready) |-> !sprite_i.ready)
    else $error("pipeline full under stall but input still ready");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && pipe.en2) |=> v2_q)
    else $error("request lost between stage one and two");

  a_skip_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !we) |-> (addr == '0))
    else $error("suppressed write carries a nonzero address");

endmodule
`default_nettype wire

/* sim/sprite_alpha_blend_rgb565_core_checker.sv */
`timescale 1ns / 100ps
module sprite_alpha_blend_rgb565_core_checker #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768,
  parameter int SPRITE_SIZE   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  sab_in_if           sprite_i,
  sab_out_if          result_i,
  output int unsigned pending_o,
  output int unsigned fail_cnt_o
);
  import sab_pkg::*;

  localparam int unsigned RedBlueMax = 31;
  localparam int unsigned GreenMax   = 63;

  typedef struct packed {
    logic        we;
    logic [19:0] addr;
    logic [15:0] pix;
  } blend_out_t;

  sab_cfg_t    origin;
  blend_out_t  blend_q[$];
  blend_out_t  want;
  int unsigned fails;

  // exact rational form of the float blend
  function automatic int unsigned mix_channel(input int unsigned under, input int unsigned over,
                                              input int unsigned a, input int unsigned maxv);
    int unsigned num;
    num = (int'(AlphaOpaque) - a) * under * int'(AlphaOpaque) + a * over * maxv;
    return num / Div;
  endfunction

  function automatic blend_out_t blend_pixel(input logic [7:0] b8, input logic [7:0] g8,
                                             input logic [7:0] r8, input logic [7:0] a,
                                             input logic [5:0] col, input logic [5:0] row,
                                             input logic [15:0] bg, input sab_cfg_t cfg);
    blend_out_t  res;
    int          sx;
    int          sy;
    int unsigned red;
    int unsigned grn;
    int unsigned blu;
    int unsigned addr;
    sx = int'($signed(cfg.origin_x)) + int'(col);
    sy = int'($signed(cfg.origin_y)) + int'(row);
    res.we   = 1'b0;
    res.addr = '0;
    res.pix  = bg;
    if (int'(col) < SPRITE_SIZE && int'(row) < SPRITE_SIZE && sx >= 0 && sx < SCREEN_WIDTH &&
        sy >= 0 && sy < SCREEN_HEIGHT && a != AlphaClear) begin
      if (a == AlphaOpaque) begin
        res.pix = {r8[7:3], g8[7:2], b8[7:3]};
      end else begin
        red = mix_channel(int'((bg & MaskRed) >> 11), int'(r8), int'(a), RedBlueMax);
        grn = mix_channel(int'((bg & MaskGreen) >> 5), int'(g8), int'(a), GreenMax);
        blu = mix_channel(int'(bg & MaskBlue), int'(b8), int'(a), RedBlueMax);
        res.pix = {red[4:0], grn[5:0], blu[4:0]};
      end
      addr     = sy * SCREEN_WIDTH + sx;
      res.we   = 1'b1;
      res.addr = addr[19:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin <= '0;
      blend_q.delete();
      fails = 0;
      pending_o <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (sab_reg_e'(paddr[2]))
          RegOriginX: origin.origin_x <= pwdata[11:0];
          RegOriginY: origin.origin_y <= pwdata[11:0];
          default: ;
        endcase
      end
      if (sprite_i.valid && sprite_i.ready) begin
        blend_q.push_back(blend_pixel(sprite_i.sprite_blue, sprite_i.sprite_green,
                                      sprite_i.sprite_red, sprite_i.sprite_alpha,
                                      sprite_i.sprite_column, sprite_i.sprite_row,
                                      sprite_i.background_pixel, origin));
      end
      if (result_i.valid && result_i.ready) begin
        if (blend_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = blend_q.pop_front();
          if (result_i.write_enable !== want.we) begin
            $error("write_enable mismatch: expected %0d, got %0d", want.we,
                   result_i.write_enable);
            fails++;
          end
          if (result_i.pixel_address !== want.addr) begin
            $error("pixel_address mismatch: expected %0h, got %0h", want.addr,
                   result_i.pixel_address);
            fails++;
          end
          if (result_i.blended_pixel !== want.pix) begin
            $error("blended_pixel mismatch: expected %0h, got %0h", want.pix,
                   result_i.blended_pixel);
            fails++;
          end
        end
      end
      pending_o <= blend_q.size();
      fail_cnt_o <= fails;
    end
  end

endmodule

/* sim/sprite_alpha_blend_rgb565_core_tb.sv */
`timescale 1ns / 100ps
module sprite_alpha_blend_rgb565_core_tb;
  import sab_pkg::*;

  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 240;
  localparam int unsigned BurstLen   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sab_in_if  sprite_if ();
  sab_out_if result_if ();

  int unsigned pending;
  int unsigned fail_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned burst_req = 0;
  int unsigned burst_seen = 0;
  int unsigned hold_left = 0;

  // origins: top-left corner, bottom-right corner, straddling each edge, fully off screen
  int origin_x_tab[NumPhases] = '{0, 960, -32, 1000, -2048, 2047, -63, 1023};
  int origin_y_tab[NumPhases] = '{0, 704, -20, 750, -2048, 2047, 767, -63};

  sprite_alpha_blend_rgb565_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sprite_i (sprite_if),
    .result_o (result_if)
  );

  sprite_alpha_blend_rgb565_core_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .sprite_i   (sprite_if),
    .result_i   (result_if),
    .pending_o  (pending),
    .fail_cnt_o (fail_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (burst_req != burst_seen) begin
        burst_seen = burst_req;
        hold_left = BurstLen;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic apb_write(input sab_reg_e idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'd0, value[11:0]};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] b8, input logic [7:0] g8, input logic [7:0] r8,
                            input logic [7:0] a, input logic [5:0] col, input logic [5:0] row,
                            input logic [15:0] bg);
    while ($urandom_range(99) < send_idle_pct) begin
      sprite_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sprite_if.valid            <= 1'b1;
    sprite_if.sprite_blue      <= b8;
    sprite_if.sprite_green     <= g8;
    sprite_if.sprite_red       <= r8;
    sprite_if.sprite_alpha     <= a;
    sprite_if.sprite_column    <= col;
    sprite_if.sprite_row       <= row;
    sprite_if.background_pixel <= bg;
    @(posedge clk_i);
    while (!sprite_if.ready) @(posedge clk_i);
  endtask

  task automatic send_random_pixel();
    logic [7:0] a;
    case ($urandom_range(9))
      0: a = AlphaClear;
      1: a = AlphaOpaque;
      default: a = 8'($urandom_range(255));
    endcase
    send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), a,
               6'($urandom_range(63)), 6'($urandom_range(63)), 16'($urandom_range(16'hFFFF)));
  endtask

  // all requests drained, then an idle wait for the pipeline
  task automatic wait_drained();
    sprite_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    rst_ni                     <= 1'b0;
    psel                       <= 1'b0;
    penable                    <= 1'b0;
    pwrite                     <= 1'b0;
    paddr                      <= '0;
    pwdata                     <= '0;
    sprite_if.valid            <= 1'b0;
    sprite_if.sprite_blue      <= '0;
    sprite_if.sprite_green     <= '0;
    sprite_if.sprite_red       <= '0;
    sprite_if.sprite_alpha     <= '0;
    sprite_if.sprite_column    <= '0;
    sprite_if.sprite_row       <= '0;
    sprite_if.background_pixel <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_write(RegOriginX, 0);
    apb_write(RegOriginY, 0);
    // transparent, opaque and blended extremes
    send_pixel(8'h00, 8'h00, 8'h00, AlphaClear, 6'd0, 6'd0, 16'hFFFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, AlphaOpaque, 6'd63, 6'd63, 16'h0000);
    send_pixel(8'h00, 8'h00, 8'h00, AlphaOpaque, 6'd0, 6'd0, 16'hFFFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'd1, 6'd1, 6'd0, 16'h0000);
    send_pixel(8'h00, 8'h00, 8'h00, 8'd254, 6'd2, 6'd0, 16'hFFFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'd128, 6'd3, 6'd1, 16'hFFFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'd128, 6'd4, 6'd2, 16'h0000);
    send_pixel(8'h00, 8'h00, 8'h00, 8'd1, 6'd5, 6'd3, 16'hFFFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'd254, 6'd6, 6'd4, 16'h0000);
    send_pixel(8'hA5, 8'h5A, 8'h3C, AlphaOpaque, 6'd7, 6'd5, 16'h1234);
    send_pixel(8'h3C, 8'hC3, 8'h96, 8'd200, 6'd0, 6'd63, 16'hA55A);
    send_pixel(8'h12, 8'h34, 8'h56, 8'd77, 6'd63, 6'd0, 16'h1234);
    wait_drained();

    // right and bottom screen edges
    apb_write(RegOriginX, 1000);
    apb_write(RegOriginY, 750);
    send_pixel(8'h80, 8'h40, 8'h20, 8'd100, 6'd23, 6'd17, 16'h7BEF);
    send_pixel(8'h80, 8'h40, 8'h20, 8'd100, 6'd24, 6'd17, 16'h7BEF);
    send_pixel(8'h80, 8'h40, 8'h20, 8'd100, 6'd23, 6'd18, 16'h7BEF);
    wait_drained();

    // left and top screen edges
    apb_write(RegOriginX, -1);
    apb_write(RegOriginY, -1);
    send_pixel(8'hFF, 8'h00, 8'hFF, AlphaOpaque, 6'd0, 6'd0, 16'h0F0F);
    send_pixel(8'hFF, 8'h00, 8'hFF, AlphaOpaque, 6'd1, 6'd0, 16'h0F0F);
    send_pixel(8'hFF, 8'h00, 8'hFF, AlphaOpaque, 6'd0, 6'd1, 16'h0F0F);
    send_pixel(8'hFF, 8'h00, 8'hFF, AlphaOpaque, 6'd1, 6'd1, 16'h0F0F);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      apb_write(RegOriginX, origin_x_tab[ph]);
      apb_write(RegOriginY, origin_y_tab[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // long result-side hold-off while requests keep coming
          burst_req <= burst_req + 1;
        end
        1: begin
          send_idle_pct  = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      repeat (PhaseItems) send_random_pixel();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
